[rtl/bdsl_pkg.sv]
// ----------------------------------------------------------------------------
// bdsl_pkg: shared types and constants of the bounded deque / sorted list
// Request codes, status codes, payload structs and the cell control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package bdsl_pkg;

  // Store geometry
  localparam int CAPACITY      = 16;
  localparam int ELEMENT_WIDTH = 32;
  localparam int CNT_W         = $clog2(CAPACITY + 1);
  localparam int IDX_W         = $clog2(CAPACITY);

  // Request codes
  localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [2:0] REQ_PUSH_REAR  = 3'd1;
  localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [2:0] REQ_POP_REAR   = 3'd3;
  localparam logic [2:0] REQ_SEARCH     = 3'd4;
  localparam logic [2:0] REQ_DELETE     = 3'd5;
  localparam logic [2:0] REQ_SORTED_INS = 3'd6;

  // Status codes
  localparam logic [1:0] STS_OK    = 2'd0;
  localparam logic [1:0] STS_EMPTY = 2'd1;
  localparam logic [1:0] STS_FULL  = 2'd2;

  // Cell load selects
  localparam logic [1:0] SEL_HOLD = 2'd0;
  localparam logic [1:0] SEL_NEW  = 2'd1;
  localparam logic [1:0] SEL_PREV = 2'd2;
  localparam logic [1:0] SEL_NEXT = 2'd3;

  typedef logic signed [ELEMENT_WIDTH-1:0] elem_t;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic signed [31:0] popped_value;
    logic               found;
    logic [1:0]         status;
    logic [4:0]         occupancy;
  } out_t;

  // Per-cell control from the sequencer
  typedef struct packed {
    logic       cmp_en;
    logic [1:0] sel;
  } cell_ctl_t;

  // Per-cell compare flags against the request value
  typedef struct packed {
    logic eq;
    logic lt;
  } cell_flag_t;

  // Sign-extend a 32-bit request word, then keep ELEMENT_WIDTH bits
  function automatic elem_t ext_elem(logic [31:0] v);
    logic [ELEMENT_WIDTH+31:0] w;
    w = {{ELEMENT_WIDTH{v[31]}}, v};
    return w[ELEMENT_WIDTH-1:0];
  endfunction

  // Element to a 32-bit result word, zero-filled above the element
  function automatic logic [31:0] out_word(elem_t e);
    logic [ELEMENT_WIDTH+31:0] w;
    w = {32'b0, e};
    return w[31:0];
  endfunction

endpackage

`default_nettype wire

[rtl/bdsl_cell.sv]
// ----------------------------------------------------------------------------
// bdsl_cell: one storage cell of the element chain
// Holds one element, compares it with the request value and loads from the
// new value or from either neighbour when the chain shifts.
// ----------------------------------------------------------------------------
`default_nettype none

module bdsl_cell
  import bdsl_pkg::*;
(
  input  wire logic       clk,
  input  wire cell_ctl_t  ctl,
  input  wire elem_t      key,
  input  wire elem_t      new_elem,
  input  wire elem_t      prev_elem,
  input  wire elem_t      next_elem,
  output elem_t           elem,
  output cell_flag_t      flags
);

  elem_t      elem_r;
  cell_flag_t flags_r;
  cell_flag_t flags_nxt;

  // Signed compare of the stored element with the request value
  always_comb begin
    flags_nxt.eq = (elem_r == key);
    flags_nxt.lt = (elem_r < key);
  end

  // Flags captured when a request is taken; element loads on a shift
  always_ff @(posedge clk) begin
    if (ctl.cmp_en) begin
      flags_r <= flags_nxt;
    end
    unique case (ctl.sel)
      SEL_HOLD: elem_r <= elem_r;
      SEL_NEW:  elem_r <= new_elem;
      SEL_PREV: elem_r <= prev_elem;
      SEL_NEXT: elem_r <= next_elem;
    endcase
  end

  assign elem  = elem_r;
  assign flags = flags_r;

endmodule

`default_nettype wire

[rtl/bounded_deque_sorted_list.sv]
// ----------------------------------------------------------------------------
// bounded_deque_sorted_list: bounded deque with sorted insert and delete
// Chain of element cells with a two-step request sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on in_valid / in_stall / in_req (type and value); one
//   result per request leaves on out_valid / out_stall / out_res.
//   A request is taken when in_valid is high and in_stall is low. In the
//   cycle it is taken every cell compares its element with the value and
//   registers equal / less flags. Once the output register is free or its
//   result leaves, the sequencer decides from those flags, shifts the chain
//   one place where needed (insert towards the rear, pop front or delete
//   towards the front) and loads the result register. A new request is not
//   taken until the previous one has loaded its result.
//   If the receiver stalls, a finished result waits in the output register;
//   a new request is still taken, and its shift waits until the held
//   result leaves. in_stall is high while the sequencer is in ST_EXEC.
//   Reset empties the store and drops any waiting result; cell contents are
//   not cleared, as only positions below the element count are ever used.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_deque_sorted_list
  import bdsl_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire in_t  in_req,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_t      out_res
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic             state_r;
  logic             state_nxt;
  logic [2:0]       req_r;
  elem_t            val_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             out_valid_r;
  out_t             out_r;
  out_t             res_nxt;

  logic             accept;
  logic             commit;
  elem_t            key;

  cell_ctl_t        ctl    [CAPACITY];
  elem_t            elems  [CAPACITY];
  cell_flag_t       flags  [CAPACITY];
  logic [1:0]       sel    [CAPACITY];

  logic [CAPACITY-1:0] eq_v;
  logic [CAPACITY-1:0] lt_v;
  logic [CAPACITY-1:0] occ;
  logic [CAPACITY-1:0] at_cnt;
  logic [CAPACITY-1:0] at_rear;
  logic [CAPACITY-1:0] cand;
  logic [CAPACITY-1:0] cand_pre;
  logic [CAPACITY-1:0] eq_pre;
  logic [CAPACITY-1:0] ins_ge;
  logic [CAPACITY-1:0] ins_ge_prev;
  logic [CAPACITY-1:0] del_ge;
  logic [CAPACITY-1:0] le_mask;
  logic                do_ins;
  logic                do_del;
  logic [CNT_W-1:0]    cnt_m1;
  logic [IDX_W-1:0]    rear_idx;
  logic                front_gt;
  logic                rear_lt;
  logic                rear_eq;

  // Handshake
  assign accept   = in_valid && !in_stall;
  assign commit   = (state_r == ST_EXEC) && (!out_valid_r || !out_stall);
  assign in_stall = (state_r == ST_EXEC);
  assign key      = ext_elem(in_req.value);

  // Cell chain
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    elem_t prev_in;
    elem_t next_in;
    if (g == 0) begin : g_first
      assign prev_in = val_r;
    end else begin : g_mid
      assign prev_in = elems[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign next_in = elems[g];
    end else begin : g_inner
      assign next_in = elems[g+1];
    end
    assign ctl[g].cmp_en = accept;
    assign ctl[g].sel    = commit ? sel[g] : SEL_HOLD;

    bdsl_cell u_cell (
      .clk       (clk),
      .ctl       (ctl[g]),
      .key       (key),
      .new_elem  (val_r),
      .prev_elem (prev_in),
      .next_elem (next_in),
      .elem      (elems[g]),
      .flags     (flags[g])
    );
  end

  // Flag vectors and position masks
  always_comb begin
    cnt_m1   = count_r - 1'b1;
    rear_idx = cnt_m1[IDX_W-1:0];
    for (int i = 0; i < CAPACITY; i++) begin
      occ[i]     = CNT_W'(i) < count_r;
      at_cnt[i]  = CNT_W'(i) >= count_r;
      at_rear[i] = CNT_W'(i) >= cnt_m1;
      eq_v[i]    = flags[i].eq && occ[i];
      lt_v[i]    = flags[i].lt;
      cand[i]    = (i != 0) && occ[i] && !flags[i].lt;
    end
    // Prefix OR: any candidate at or below each position
    for (int i = 0; i < CAPACITY; i++) begin
      le_mask     = {CAPACITY{1'b1}} >> (CAPACITY - 1 - i);
      cand_pre[i] = |(cand & le_mask);
      eq_pre[i]   = |(eq_v & le_mask);
    end
    front_gt = !flags[0].eq && !flags[0].lt;
    rear_lt  = lt_v[rear_idx];
    rear_eq  = eq_v[rear_idx];
  end

  // Request decode
  always_comb begin
    count_nxt           = count_r;
    res_nxt.popped_value = '0;
    res_nxt.found        = 1'b0;
    res_nxt.status       = STS_OK;
    ins_ge              = '0;
    del_ge              = '0;
    do_ins              = 1'b0;
    do_del              = 1'b0;

    unique case (req_r)
      REQ_PUSH_FRONT, REQ_PUSH_REAR, REQ_SORTED_INS: begin
        if (count_r == CNT_W'(CAPACITY)) begin
          res_nxt.status = STS_FULL;
        end else begin
          do_ins    = 1'b1;
          count_nxt = count_r + 1'b1;
          if (req_r == REQ_PUSH_FRONT || count_r == '0) begin
            ins_ge = '1;
          end else if (req_r == REQ_PUSH_REAR) begin
            ins_ge = at_cnt;
          end else if (front_gt) begin
            ins_ge = '1;
          end else if (rear_lt) begin
            ins_ge = at_cnt;
          end else begin
            ins_ge = cand_pre | at_cnt;
          end
        end
      end
      REQ_POP_FRONT, REQ_POP_REAR: begin
        if (count_r == '0) begin
          res_nxt.status = STS_EMPTY;
        end else begin
          count_nxt = cnt_m1;
          if (req_r == REQ_POP_FRONT) begin
            res_nxt.popped_value = out_word(elems[0]);
            do_del = 1'b1;
            del_ge = '1;
          end else begin
            res_nxt.popped_value = out_word(elems[rear_idx]);
          end
        end
      end
      REQ_SEARCH: begin
        res_nxt.found = |eq_v;
      end
      REQ_DELETE: begin
        if (|eq_v) begin
          res_nxt.found = 1'b1;
          count_nxt     = cnt_m1;
          do_del        = 1'b1;
          if (eq_v[0]) begin
            del_ge = '1;
          end else if (rear_eq) begin
            del_ge = at_rear;
          end else begin
            del_ge = eq_pre;
          end
        end
      end
      default: begin
      end
    endcase

    res_nxt.occupancy = 5'(count_nxt);
  end

  // Per-cell load selects
  always_comb begin
    ins_ge_prev = {ins_ge[CAPACITY-2:0], 1'b0};
    for (int i = 0; i < CAPACITY; i++) begin
      priority if (do_ins && ins_ge_prev[i]) begin
        sel[i] = SEL_PREV;
      end else if (do_ins && ins_ge[i]) begin
        sel[i] = SEL_NEW;
      end else if (do_del && del_ge[i]) begin
        sel[i] = SEL_NEXT;
      end else begin
        sel[i] = SEL_HOLD;
      end
    end
  end

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    if (accept) begin
      state_nxt = ST_EXEC;
    end else if (commit) begin
      state_nxt = ST_IDLE;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_req.req_type;
      val_r <= key;
    end
    if (commit) begin
      out_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

endmodule

`default_nettype wire
